/* src/assert_macros.svh */
// Assertion macros for the RTL, included by the table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/shbt_pkg.sv */
// Package with types, constants and helpers for the sparse histogram table.
package shbt_pkg;
	localparam int ENTRIES = 256;
	localparam int INDEX_BITS = 16;
	localparam int POP_W = $clog2(ENTRIES + 1);
	localparam int CNT_W = 63;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_RANK = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_WORK = 2'd1,
		ST_RANK = 2'd2,
		ST_OUT = 2'd3
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] bucket;
		logic [62:0] amount;
		logic [62:0] target_count;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [62:0] count;
		logic found;
		logic [15:0] bucket_found;
		logic [8:0] populated;
	} out_item_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic insert;
		logic update;
		logic rank_load;
		logic rank_step;
		logic [INDEX_BITS-1:0] key;
		logic [CNT_W-1:0] amount;
	} cell_cmd_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction
endpackage

/* src/shbt_cell.sv */
// One table cell: holds one sorted entry, compares, shifts and passes rank data.
module shbt_cell
	import shbt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cell_cmd_t cmd,
	input logic valid_in,
	input logic prev_gt,
	input logic [INDEX_BITS-1:0] prev_key,
	input logic [CNT_W-1:0] prev_cnt,
	input logic [CNT_W-1:0] prev_run,
	input logic prev_hit,
	output logic self_gt,
	output logic self_eq,
	output logic [INDEX_BITS-1:0] key_q,
	output logic [CNT_W-1:0] cnt_q,
	output logic [CNT_W-1:0] run_q,
	output logic hit_q
);
	logic [CNT_W-1:0] run_next;

	assign self_gt = valid_in && (key_q > cmd.key);
	assign self_eq = valid_in && (key_q == cmd.key);
	assign run_next = sat_add(prev_run, cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.insert && self_gt) begin
			if (prev_gt) begin
				key_q <= prev_key;
				cnt_q <= prev_cnt;
			end else begin
				key_q <= cmd.key;
				cnt_q <= cmd.amount;
			end
		end else if (cmd.insert && !valid_in && !prev_gt) begin
			key_q <= cmd.key;
			cnt_q <= cmd.amount;
		end else if (cmd.insert && !valid_in) begin
			key_q <= prev_key;
			cnt_q <= prev_cnt;
		end else if (cmd.update && self_eq) begin
			cnt_q <= sat_add(cnt_q, cmd.amount);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.rank_load) begin
			run_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.rank_step) begin
			run_q <= run_next;
			hit_q <= prev_hit;
		end
	end
endmodule

/* src/shbt_ctrl.sv */
// Sequencer for the table: item decode, cell commands, rank wave and result.
module shbt_ctrl
	import shbt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	output cell_cmd_t cmd,
	output logic [POP_W-1:0] pop_q,
	input logic any_eq,
	input logic [CNT_W-1:0] eq_cnt,
	input logic rank_hit,
	input logic [INDEX_BITS-1:0] rank_key
);
	state_t state_q, state_next;
	in_item_t item_q;
	out_item_t res_q;
	logic [POP_W-1:0] steps_q;
	logic full;

	assign full = (pop_q == POP_W'(ENTRIES));

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_next = ST_WORK;
			ST_WORK: state_next = (item_q.kind == KIND_RANK) ? ST_RANK : ST_OUT;
			ST_RANK: if (steps_q == '0) state_next = ST_OUT;
			ST_OUT: if (!out_stall) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.key = item_q.bucket[INDEX_BITS-1:0];
		cmd.amount = item_q.amount;
		if (state_q == ST_WORK) begin
			case (kind_t'(item_q.kind))
				KIND_ADD: begin
					cmd.update = any_eq;
					cmd.insert = !any_eq && item_q.amount != '0 && !full;
				end
				KIND_RANK: cmd.rank_load = 1'b1;
				default: cmd = cmd;
			endcase
		end
		if (state_q == ST_RANK) cmd.rank_step = 1'b1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pop_q <= '0;
			steps_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_WORK) begin
				steps_q <= pop_q;
				if (item_q.kind == KIND_CLEAR) pop_q <= '0;
				else if (cmd.insert) pop_q <= pop_q + 1'b1;
			end else if (state_q == ST_RANK) begin
				steps_q <= steps_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) item_q <= in_item;
		if (state_q == ST_WORK) begin
			res_q <= '0;
			case (kind_t'(item_q.kind))
				KIND_ADD: begin
					if (any_eq) begin
						res_q.count <= sat_add(eq_cnt, item_q.amount);
						res_q.found <= 1'b1;
						res_q.populated <= pop_q;
					end else if (item_q.amount == '0) begin
						res_q.populated <= pop_q;
					end else if (full) begin
						res_q.status <= 1'b1;
						res_q.populated <= pop_q;
					end else begin
						res_q.count <= item_q.amount;
						res_q.found <= 1'b1;
						res_q.populated <= pop_q + 1'b1;
					end
				end
				KIND_LOOKUP: begin
					res_q.count <= any_eq ? eq_cnt : '0;
					res_q.found <= any_eq;
					res_q.populated <= pop_q;
				end
				KIND_RANK: res_q.populated <= pop_q;
				default: res_q.populated <= '0;
			endcase
		end else if (state_q == ST_RANK && steps_q == '0 && rank_hit) begin
			res_q.found <= 1'b1;
			res_q.bucket_found <= 16'(rank_key);
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_pop_range, clk, arst_n, 1'b1, pop_q <= POP_W'(ENTRIES),
		"population above capacity")
	`ASSERT_NEXT(a_clear_empty, clk, arst_n,
		state_q == ST_WORK && item_q.kind == KIND_CLEAR, pop_q == '0,
		"clear left entries")
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, 1'b1, !(cmd.insert && cmd.update),
		"insert and update together")
endmodule

/* src/sparse_histogram_bucket_table.sv */
// Top level: sorted cell chain with sequencer for the sparse histogram table.
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_item_t
//  out     | output    | out_valid/stall | out_item_t
// Add, lookup and clear pass through a work state, then the output state, where
// the result waits for the handshake; the cell chain compares all entries
// combinationally and shifts the larger ones in the work state. A rank query adds
// a rank state, in which the running sum ripples one cell a cycle along the chain
// and is read once it has crossed every entry. Reset empties the table at once.
// While a result waits under out_stall, no new input is taken.
module sparse_histogram_bucket_table
	import shbt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item
);
	cell_cmd_t cmd;
	logic [POP_W-1:0] pop_q;
	logic [ENTRIES-1:0] gt, eq, hit, vld, reach, prev_gts;
	logic [INDEX_BITS-1:0] keys [ENTRIES];
	logic [CNT_W-1:0] cnts [ENTRIES];
	logic [CNT_W-1:0] runs [ENTRIES];
	logic [INDEX_BITS-1:0] prev_keys [ENTRIES];
	logic [CNT_W-1:0] prev_cnts [ENTRIES];
	logic [CNT_W-1:0] prev_runs [ENTRIES];
	logic [CNT_W-1:0] eq_cnt, tgt;
	logic [INDEX_BITS-1:0] rank_key;
	logic any_eq, rank_hit;
	in_item_t item_cap_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_cap_q <= in_item;
	end
	assign tgt = (item_cap_q.target_count == '0) ? CNT_W'(1) : item_cap_q.target_count;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign prev_gts[g] = 1'b0;
				assign prev_keys[g] = '0;
				assign prev_cnts[g] = '0;
				assign prev_runs[g] = '0;
			end else begin : g_link
				assign prev_gts[g] = gt[g-1];
				assign prev_keys[g] = keys[g-1];
				assign prev_cnts[g] = cnts[g-1];
				assign prev_runs[g] = runs[g-1];
			end
			assign vld[g] = (POP_W'(g) < pop_q);
			assign reach[g] = vld[g] && (sat_add(prev_runs[g], cnts[g]) >= tgt);
			shbt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .valid_in(vld[g]),
				.prev_gt(prev_gts[g]),
				.prev_key(prev_keys[g]),
				.prev_cnt(prev_cnts[g]),
				.prev_run(prev_runs[g]),
				.prev_hit(reach[g]),
				.self_gt(gt[g]), .self_eq(eq[g]), .key_q(keys[g]), .cnt_q(cnts[g]),
				.run_q(runs[g]), .hit_q(hit[g])
			);
		end
	endgenerate

	always_comb begin
		eq_cnt = '0;
		rank_key = '0;
		rank_hit = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (eq[i]) eq_cnt = cnts[i];
			if (hit[i]) begin
				rank_key = keys[i];
				rank_hit = 1'b1;
			end
		end
	end
	assign any_eq = |eq;

	shbt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_item), .cmd(cmd), .pop_q(pop_q), .any_eq(any_eq),
		.eq_cnt(eq_cnt), .rank_hit(rank_hit), .rank_key(rank_key)
	);
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the sparse histogram bucket table.
module testbench;
	import shbt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	sparse_histogram_bucket_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always #2 clk = ~clk;

	logic [15:0] table_keys[$];
	logic [62:0] table_counts[$];
	out_item_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	bit sink_idle_on = 1'b1;
	bit source_idle_on = 1'b1;
	int stall_left = 0;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic logic [62:0] add_sat(input logic [62:0] a, input logic [62:0] b);
		logic [63:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[63] ? COUNT_MAX : s[62:0];
	endfunction

	function automatic out_item_t predict_histogram(input in_item_t it);
		out_item_t r;
		logic [62:0] run;
		logic [62:0] tgt;
		int p;
		bit hit;
		r = '0;
		case (kind_t'(it.kind))
			KIND_CLEAR: begin
				table_keys.delete();
				table_counts.delete();
			end
			KIND_RANK: begin
				run = '0;
				tgt = (it.target_count == 0) ? 63'd1 : it.target_count;
				foreach (table_counts[i]) begin
					run = add_sat(run, table_counts[i]);
					if (run >= tgt) begin
						r.found = 1'b1;
						r.bucket_found = table_keys[i];
						break;
					end
				end
			end
			default: begin
				p = 0;
				while (p < table_keys.size() && table_keys[p] < it.bucket)
					p++;
				hit = p < table_keys.size() && table_keys[p] == it.bucket;
				if (it.kind == KIND_LOOKUP) begin
					if (hit) begin
						r.count = table_counts[p];
						r.found = 1'b1;
					end
				end else if (hit) begin
					table_counts[p] = add_sat(table_counts[p], it.amount);
					r.count = table_counts[p];
					r.found = 1'b1;
				end else if (it.amount != 0) begin
					if (table_keys.size() >= ENTRIES) begin
						r.status = 1'b1;
					end else begin
						table_keys.insert(p, it.bucket);
						table_counts.insert(p, it.amount);
						r.count = it.amount;
						r.found = 1'b1;
					end
				end
			end
		endcase
		r.populated = 9'(table_keys.size());
		return r;
	endfunction

	task automatic send_item(input kind_t k, input logic [15:0] b, input logic [62:0] a,
			input logic [62:0] t);
		in_item_t it;
		int gap;
		it.kind = k;
		it.bucket = b;
		it.amount = a;
		it.target_count = t;
		if (source_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_histogram(it));
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!sink_idle_on)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 16);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		cycles++;
		if (cycles > 3000000) begin
			$display("testbench failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report("result with nothing expected");
			end else begin
				e = expected_results.pop_front();
				if (out_item.status !== e.status)
					report($sformatf("status %b want %b", out_item.status, e.status));
				if (out_item.count !== e.count)
					report($sformatf("count %0d want %0d", out_item.count, e.count));
				if (out_item.found !== e.found)
					report($sformatf("found %b want %b", out_item.found, e.found));
				if (out_item.bucket_found !== e.bucket_found)
					report($sformatf("bucket_found %0d want %0d", out_item.bucket_found,
						e.bucket_found));
				if (out_item.populated !== e.populated)
					report($sformatf("populated %0d want %0d", out_item.populated,
						e.populated));
			end
		end
	end

	function automatic logic [62:0] rand_count();
		case ($urandom_range(0, 4))
			0: return 63'd0;
			1: return COUNT_MAX;
			2: return 63'({$urandom, $urandom});
			default: return 63'($urandom_range(1, 100));
		endcase
	endfunction

	task automatic test_directed();
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd0);
		send_item(KIND_LOOKUP, 16'hFFFF, 63'd0, 63'd0);
		send_item(KIND_ADD, 16'd5, 63'd0, 63'd0);
		send_item(KIND_ADD, 16'hFFFF, 63'd3, 63'd0);
		send_item(KIND_ADD, 16'd0, 63'd2, 63'd0);
		send_item(KIND_ADD, 16'd100, COUNT_MAX, 63'd0);
		send_item(KIND_ADD, 16'd100, 63'd1, 63'd0);
		send_item(KIND_ADD, 16'd0, 63'd0, 63'd0);
		send_item(KIND_LOOKUP, 16'd100, 63'd0, 63'd0);
		send_item(KIND_LOOKUP, 16'd7, COUNT_MAX, COUNT_MAX);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd0);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd3);
		send_item(KIND_RANK, 16'd0, 63'd0, COUNT_MAX);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd6);
		send_item(KIND_CLEAR, 16'hFFFF, COUNT_MAX, COUNT_MAX);
		send_item(KIND_LOOKUP, 16'd0, 63'd0, 63'd0);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd1);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < ENTRIES; i++)
			send_item(KIND_ADD, 16'(i * 200), 63'd1, 63'd0);
		send_item(KIND_ADD, 16'd1, 63'd4, 63'd0);
		send_item(KIND_ADD, 16'd1, 63'd0, 63'd0);
		send_item(KIND_ADD, 16'd400, 63'd4, 63'd0);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd256);
		send_item(KIND_RANK, 16'd0, 63'd0, 63'd300);
		send_item(KIND_CLEAR, 16'd0, 63'd0, 63'd0);
	endtask

	task automatic test_random(input int n);
		logic [15:0] b;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
			if (r < 50)
				send_item(KIND_ADD, b, rand_count(), 63'($urandom));
			else if (r < 75)
				send_item(KIND_LOOKUP, b, 63'({$urandom, $urandom}),
					63'({$urandom, $urandom}));
			else if (r < 97)
				send_item(KIND_RANK, b, 63'({$urandom, $urandom}), rand_count());
			else
				send_item(KIND_CLEAR, b, 63'({$urandom, $urandom}),
					63'({$urandom, $urandom}));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		test_random(900);
		sink_idle_on = 1'b0;
		source_idle_on = 1'b0;
		test_random(100);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
